[hw/rtl/nta_pkg.sv]
package nta_pkg;

  // Fixed word layout
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 7;
  localparam int DEC_DIGITS = 20;            // digits of 2^64-1
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int MAX_CHARS  = 32;
  localparam int MAX_FRAC   = 16;
  localparam int HEX_DIGITS = VALUE_W / 4;

  localparam int FRACTION_BITS_DEF = 16;

  // Operation codes
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam logic [1:0] OP_FIX  = 2'd3;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;  // 'A' - 10

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         operation;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_word_t;

  // Character source for the output register
  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_X,
    SEL_MINUS,
    SEL_DOT,
    SEL_BCD,
    SEL_HEX,
    SEL_FRAC
  } char_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      bcd_shift;
    logic      hex_shift;
    logic      frac_step;
    logic      emit;
    logic      last;
    char_sel_t sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic top_zero;
    logic frac_zero;
    logic frac_next_zero;
  } dp_stat_t;

  // Uppercase hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO | {3'b000, nib};
    end else begin
      c = CH_ALPHA + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

[hw/rtl/nta_datapath.sv]
module nta_datapath #(
  parameter int FRACTION_BITS = nta_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nta_pkg::in_word_t   in_word,
  input  nta_pkg::dp_cmd_t    cmd,
  output nta_pkg::dp_stat_t   stat,
  output logic                out_strobe,
  output nta_pkg::out_word_t  out_word
);
  import nta_pkg::*;

  // fraction width held to 1..32
  localparam int FB = (FRACTION_BITS < 1) ? 1 :
                      (FRACTION_BITS > 32) ? 32 : FRACTION_BITS;

  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, bcd_adj;
  logic [FB-1:0]      frac_r, frac_nxt;
  logic [FB+3:0]      prod;
  logic               out_valid_r;
  out_word_t          out_word_r, out_word_nxt;

  // Add-3 correction of every BCD digit before the shift
  always_comb begin
    logic [3:0] dig;
    for (int d = 0; d < DEC_DIGITS; d++) begin
      dig = bcd_r[d*4 +: 4];
      bcd_adj[d*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Fraction times ten: 8f + 2f
  assign prod = {3'b000, frac_r, 1'b0} + {1'b0, frac_r, 3'b000};

  // Operand registers
  always_comb begin
    val_nxt  = val_r;
    bcd_nxt  = bcd_r;
    frac_nxt = frac_r;
    if (cmd.load) begin
      if (in_word.operation == OP_SDEC && in_word.value[VALUE_W-1]) begin
        val_nxt = {VALUE_W{1'b0}} - in_word.value;
      end else if (in_word.operation == OP_FIX) begin
        val_nxt = in_word.value >> FB;
      end else begin
        val_nxt = in_word.value;
      end
      bcd_nxt  = '0;
      frac_nxt = in_word.value[FB-1:0];
    end else if (cmd.conv_step) begin
      {bcd_nxt, val_nxt} = {bcd_adj[BCD_W-2:0], val_r, 1'b0};
    end else if (cmd.bcd_shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
    end else if (cmd.hex_shift) begin
      val_nxt = {val_r[VALUE_W-5:0], 4'h0};
    end else if (cmd.frac_step) begin
      frac_nxt = prod[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    bcd_r  <= bcd_nxt;
    frac_r <= frac_nxt;
  end

  // Character selection
  always_comb begin
    out_word_nxt.last = cmd.last;
    case (cmd.sel)
      SEL_ZERO:  out_word_nxt.character = CH_ZERO;
      SEL_X:     out_word_nxt.character = CH_X;
      SEL_MINUS: out_word_nxt.character = CH_MINUS;
      SEL_DOT:   out_word_nxt.character = CH_DOT;
      SEL_BCD:   out_word_nxt.character = CH_ZERO | {3'b000, bcd_r[BCD_W-1 -: 4]};
      SEL_HEX:   out_word_nxt.character = hex_char(val_r[VALUE_W-1 -: 4]);
      SEL_FRAC:  out_word_nxt.character = CH_ZERO | {3'b000, prod[FB+3:FB]};
      default:   out_word_nxt.character = CH_ZERO;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign stat.top_zero       = (bcd_r[BCD_W-1 -: 4] == 4'h0);
  assign stat.frac_zero      = (frac_r == '0);
  assign stat.frac_next_zero = (prod[FB-1:0] == '0);

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule

[hw/rtl/nta_ctrl.sv]
module nta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  nta_pkg::in_word_t  in_word,
  input  nta_pkg::dp_stat_t  stat,
  output nta_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import nta_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_PRE  = 8'b00000010,
    S_CONV = 8'b00000100,
    S_SKIP = 8'b00001000,
    S_DEC  = 8'b00010000,
    S_DOT  = 8'b00100000,
    S_FRAC = 8'b01000000,
    S_HEX  = 8'b10000000
  } state_t;

  localparam logic [5:0] ConvLast  = 6'(VALUE_W - 1);
  localparam logic [5:0] DigitsAll = 6'(DEC_DIGITS);
  localparam logic [5:0] HexLast   = 6'(HEX_DIGITS - 1);
  localparam logic [5:0] FracLast  = 6'(MAX_FRAC - 1);
  localparam logic [5:0] CharsLast = 6'(MAX_CHARS - 1);

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [5:0] cnt_r, cnt_nxt;     // bit, digit or character step
  logic [5:0] chars_r, chars_nxt; // characters sent for this word

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = SEL_ZERO;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_nxt   = in_word.operation;
          cnt_nxt  = '0;
          if (in_word.operation == OP_HEX ||
              (in_word.operation == OP_SDEC && in_word.value[VALUE_W-1])) begin
            state_nxt = S_PRE;
          end else begin
            state_nxt = S_CONV;
          end
        end
      end
      // "0x" prefix or minus sign
      S_PRE: begin
        cmd.emit = 1'b1;
        if (op_r == OP_HEX) begin
          cmd.sel = (cnt_r == '0) ? SEL_ZERO : SEL_X;
          if (cnt_r == '0) begin
            cnt_nxt = 6'd1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_HEX;
          end
        end else begin
          cmd.sel   = SEL_MINUS;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      // one binary bit into the BCD register per cycle
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (cnt_r == ConvLast) begin
          cnt_nxt   = DigitsAll;
          state_nxt = S_SKIP;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      // drop leading zero digits, keep at least one
      S_SKIP: begin
        if (stat.top_zero && cnt_r > 6'd1) begin
          cmd.bcd_shift = 1'b1;
          cnt_nxt       = cnt_r - 6'd1;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.emit      = 1'b1;
        cmd.sel       = SEL_BCD;
        cmd.bcd_shift = 1'b1;
        cmd.last      = (cnt_r == 6'd1) && (op_r != OP_FIX);
        cnt_nxt       = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = (op_r == OP_FIX) ? S_DOT : S_IDLE;
        end
      end
      S_DOT: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_DOT;
        cmd.last  = stat.frac_zero || (chars_r == CharsLast);
        cnt_nxt   = '0;
        state_nxt = cmd.last ? S_IDLE : S_FRAC;
      end
      // one fraction digit per cycle
      S_FRAC: begin
        cmd.emit      = 1'b1;
        cmd.sel       = SEL_FRAC;
        cmd.frac_step = 1'b1;
        cmd.last      = stat.frac_next_zero || (cnt_r == FracLast) ||
                        (chars_r == CharsLast);
        cnt_nxt       = cnt_r + 6'd1;
        if (cmd.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_HEX: begin
        cmd.emit      = 1'b1;
        cmd.sel       = SEL_HEX;
        cmd.hex_shift = 1'b1;
        cmd.last      = (cnt_r == HexLast);
        cnt_nxt       = cnt_r + 6'd1;
        if (cmd.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // character count
  always_comb begin
    chars_nxt = chars_r;
    if (state_r == S_IDLE) begin
      chars_nxt = '0;
    end else if (cmd.emit) begin
      chars_nxt = chars_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_SDEC;
      cnt_r   <= '0;
      chars_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      chars_r <= chars_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // checks
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_chars_cap: assert property (@(posedge clk) disable iff (!rst_n)
    chars_r <= 6'(MAX_CHARS))
    else $error("more than the maximum characters sent");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.last |=> state_r == S_IDLE)
    else $error("controller kept running after the last character");

  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SKIP || state_r == S_DEC |-> cnt_r >= 6'd1 && cnt_r <= DigitsAll)
    else $error("digit count out of range");

  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV || state_r == S_SKIP || state_r == S_IDLE |-> !cmd.emit)
    else $error("character sent outside an emitting state");

endmodule

[hw/rtl/number_to_ascii_formatter_core.sv]
// Channel   Ports                    Handshake
// input     start, busy, in_word     taken at an edge with start high, busy low
// result    out_strobe, out_word     one strobe per character, always taken
//
// Hex: the two prefix characters, then 16 digits, one character per cycle.
// Decimal and fixed point: optional sign character, shift-add-3 conversion
// of all 64 bits, dropping of leading zeros (at least one digit is kept),
// then one character per integer digit, dot and fraction digit.
// Synchronous active-low reset returns the controller to idle.
// The receiver cannot stall; busy holds off new words until the text is done.
module number_to_ascii_formatter_core #(
  parameter int FRACTION_BITS = nta_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nta_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output nta_pkg::out_word_t  out_word
);
  import nta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  nta_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

[tb/tb_number_to_ascii_formatter_core.sv]
module tb_number_to_ascii_formatter_core;
  import nta_pkg::*;

  localparam int FRAC_BITS    = FRACTION_BITS_DEF;
  localparam int RANDOM_WORDS = 250;
  localparam int QUIET_TAIL   = 40;     // last random words sent without gaps
  localparam int HOLD_POINT   = 120;    // sender waits for an empty queue here
  localparam int DRAIN_CYCLES = 200;    // extra wait after the queue empties
  localparam int CYCLE_LIMIT  = 300000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  out_word_t                expected_chars[$];
  logic [CHAR_W-1:0]        text_buf[$];
  in_word_t                 dir_words[$];
  string                    dir_texts[$];
  int                       error_count = 0;
  int                       cycle_count = 0;

  number_to_ascii_formatter_core #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Move the text buffer onto the expected characters, last flag on the end
  function automatic void commit_text();
    out_word_t e;
    for (int i = 0; i < text_buf.size(); i++) begin
      e.character = text_buf[i];
      e.last      = (i == text_buf.size() - 1);
      expected_chars.push_back(e);
    end
    text_buf.delete();
  endfunction

  // Decimal digits of u, most significant first, capped at the text limit
  function automatic void append_decimal(logic [63:0] u);
    logic [CHAR_W-1:0] rev[$];
    do begin
      rev.push_back(CH_ZERO + CHAR_W'(u % 64'd10));
      u = u / 64'd10;
    end while (u != 64'd0);
    while (rev.size() > 0 && text_buf.size() < MAX_CHARS)
      text_buf.push_back(rev.pop_back());
  endfunction

  // Expected text of one input word
  function automatic void format_expected(in_word_t w);
    int          fb;
    int          k;
    logic [63:0] mask;
    logic [63:0] frac;
    logic [3:0]  nib;
    text_buf.delete();
    case (w.operation)
      OP_SDEC: begin
        if (w.value[63]) begin
          text_buf.push_back(CH_MINUS);
          append_decimal(64'd0 - w.value);
        end else begin
          append_decimal(w.value);
        end
      end
      OP_UDEC: append_decimal(w.value);
      OP_HEX: begin
        text_buf.push_back(CH_ZERO);
        text_buf.push_back(CH_X);
        for (int i = 15; i >= 0; i--) begin
          nib = w.value[i*4 +: 4];
          if (nib < 4'd10) text_buf.push_back(CH_ZERO + CHAR_W'(nib));
          else text_buf.push_back(7'h41 + CHAR_W'(nib - 4'd10));
        end
      end
      default: begin
        fb = (FRAC_BITS < 1) ? 1 : (FRAC_BITS > 32) ? 32 : FRAC_BITS;
        mask = (64'd1 << fb) - 64'd1;
        frac = w.value & mask;
        k = 0;
        append_decimal(w.value >> fb);
        if (text_buf.size() < MAX_CHARS) text_buf.push_back(CH_DOT);
        // fraction digits by repeated times ten
        while (frac != 64'd0 && k < MAX_FRAC && text_buf.size() < MAX_CHARS) begin
          frac = frac * 64'd10;
          text_buf.push_back(CH_ZERO + CHAR_W'(frac >> fb));
          frac = frac & mask;
          k++;
        end
      end
    endcase
    commit_text();
  endfunction

  // Typed-in expected text
  function automatic void expect_text(string s);
    byte c;
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      text_buf.push_back(c[CHAR_W-1:0]);
    end
    commit_text();
  endfunction

  function automatic void add_row(logic [1:0] op, logic [63:0] v, string s);
    in_word_t w;
    w.operation = op;
    w.value     = v;
    dir_words.push_back(w);
    dir_texts.push_back(s);
  endfunction

  // Offer one word; expectations are queued at the accepting edge
  task automatic send_word(in_word_t w, string s);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (s.len() == 0) format_expected(w);
    else expect_text(s);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Operand mix: full range, small, truncated, negative, short fractions, powers
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [15:0] f;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 1000));
      2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: v = 64'd0 - 64'($urandom_range(1, 100000));
      4: begin
        f = 16'($urandom) & ~((16'd1 << $urandom_range(0, 16)) - 16'd1);
        v = (({$urandom, $urandom} >> $urandom_range(16, 63)) << 16) | 64'(f);
      end
      default: begin
        v = 64'd1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = v - 64'd1;
      end
    endcase
    return v;
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: character %h last %b", out_word.character, out_word.last);
        error_count++;
      end else begin
        e = expected_chars.pop_front();
        if (out_word.character !== e.character) begin
          $error("character: expected %h actual %h", e.character, out_word.character);
          error_count++;
        end
        if (out_word.last !== e.last) begin
          $error("last: expected %b actual %b", e.last, out_word.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_word_t w;
    // directed words; empty text means predicted
    add_row(OP_SDEC, 64'd0, "0");
    add_row(OP_SDEC, 64'd1, "1");
    add_row(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, "-1");
    add_row(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807");
    add_row(OP_SDEC, 64'h8000_0000_0000_0000, "-9223372036854775808");
    add_row(OP_SDEC, 64'h8000_0000_0000_0001, "");
    add_row(OP_SDEC, 64'd1234567890, "");
    add_row(OP_UDEC, 64'd0, "0");
    add_row(OP_UDEC, 64'd9, "9");
    add_row(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615");
    add_row(OP_UDEC, 64'h8000_0000_0000_0000, "9223372036854775808");
    add_row(OP_UDEC, 64'd10000000000000000000, "10000000000000000000");
    add_row(OP_HEX, 64'd0, "0x0000000000000000");
    add_row(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, "0xFFFFFFFFFFFFFFFF");
    add_row(OP_HEX, 64'h0123_4567_89AB_CDEF, "0x0123456789ABCDEF");
    add_row(OP_HEX, 64'hFEDC_BA98_7654_3210, "");
    add_row(OP_FIX, 64'd0, "0.");
    add_row(OP_FIX, 64'h1_0000, "1.");
    add_row(OP_FIX, 64'h8000, "0.5");
    add_row(OP_FIX, 64'h1_8000, "1.5");
    add_row(OP_FIX, 64'h3_4000, "3.25");
    add_row(OP_FIX, 64'h1, "0.0000152587890625");
    add_row(OP_FIX, 64'hFFFF_FFFF_FFFF_0000, "281474976710655.");
    add_row(OP_FIX, 64'hFFFF_FFFF_FFFF_FFFF, "281474976710655.9999847412109375");
    add_row(OP_FIX, 64'h0000_1234_5678_9ABC, "");

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_words.size(); i++) begin
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 10));
      send_word(dir_words[i], dir_texts[i]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // hold until the block has drained every text
      if (i == HOLD_POINT) begin
        @(negedge clk);
        start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
      end
      if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_cycles($urandom_range(1, 10));
      w.operation = 2'($urandom_range(0, 3));
      w.value     = random_value();
      send_word(w, "");
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
